// ===== rtl/plbo_pkg.sv =====
package plbo_pkg;

   localparam int COORD_W       = 12;
   localparam int SPAN_W        = 13;
   localparam int SUM_W         = COORD_W + 2;
   localparam int CHAN_W        = 8;
   localparam int CHAN_NUM      = 3;
   localparam int ALPHA_W       = 8;
   localparam int PROD_W        = 2 * CHAN_W;

   localparam int STRIP_WIDTH   = 16;
   localparam int STRIP_HEIGHT  = 112;
   localparam int STRIP_LAST    = STRIP_HEIGHT - 1;
   localparam int ROW_W         = $clog2(STRIP_HEIGHT);
   localparam int COL_W         = $clog2(STRIP_WIDTH);

   localparam int PALETTE_DEPTH = 256;
   localparam int PAL_W         = $clog2(PALETTE_DEPTH);
   localparam int PAL_MAX       = PALETTE_DEPTH - 1;

   localparam int ALPHA_MAX     = 255;
   localparam int OUTLINE_ALPHA = 204;
   localparam int OUTLINE_KEEP  = ALPHA_MAX - OUTLINE_ALPHA;
   localparam int ROUND_BIAS    = 127;

   localparam int CSR_IDX_W     = 3;
   localparam int CSR_DATA_W    = SPAN_W;

   localparam int REQ_DATA_W    = 2 * COORD_W + PAL_W + CHAN_NUM * CHAN_W;
   localparam int RSP_DATA_W    = CHAN_NUM * CHAN_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STRIP_LEFT  = 3'd0,
      CSR_STRIP_TOP   = 3'd1,
      CSR_FILL_ALPHA  = 3'd2,
      CSR_CLIP_LEFT   = 3'd3,
      CSR_CLIP_TOP    = 3'd4,
      CSR_CLIP_WIDTH  = 3'd5,
      CSR_CLIP_HEIGHT = 3'd6
   } csr_index_type;

   typedef enum logic {
      CMD_LOAD  = 1'b0,
      CMD_PIXEL = 1'b1
   } command_type;

   // Index 0 is red, 1 green, 2 blue.
   typedef logic [CHAN_NUM-1:0][CHAN_W-1:0] rgb_type;
   typedef logic [CHAN_NUM-1:0][PROD_W-1:0] rgb_sum_type;

   typedef logic [PAL_W-1:0] grad_table_type [STRIP_HEIGHT];

   // Palette index of each strip row, rounded to nearest, top row brightest.
   function automatic grad_table_type build_grad_table();
      grad_table_type tbl;
      for (int i = 0; i < STRIP_HEIGHT; i++) begin
         tbl[i] = PAL_W'(PAL_MAX - (i * PAL_MAX + STRIP_LAST / 2) / STRIP_LAST);
      end
      return tbl;
   endfunction

   localparam grad_table_type GRAD_TABLE = build_grad_table();

   // Exact x / 255 for any x up to 255 * 255 + 127.
   function automatic logic [CHAN_W-1:0] div255(input logic [PROD_W-1:0] x);
      logic [PROD_W:0] t;
      t = {1'b0, x} + (PROD_W+1)'(1) + (PROD_W+1)'(x[PROD_W-1:CHAN_W]);
      return t[PROD_W-1:CHAN_W];
   endfunction

endpackage

// ===== rtl/plbo_palette_ram.sv =====
module plbo_palette_ram (
   input  logic                   clock,
   input  logic                   wr_en,
   input  logic [plbo_pkg::PAL_W-1:0] wr_addr,
   input  plbo_pkg::rgb_type      wr_data,
   input  logic                   rd_en,
   input  logic [plbo_pkg::PAL_W-1:0] rd_addr,
   output plbo_pkg::rgb_type      rd_data
);
   import plbo_pkg::*;

   rgb_type mem [PALETTE_DEPTH];
   rgb_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/palette_legend_bar_overlay_unit.sv =====
// Palette legend bar overlay.
// Draws a vertical gradient strip, colored from a 256-entry palette and
// outlined by a translucent black one-pixel frame, over an RGB888 stream.
// req_ channel: one transaction per pixel or palette load; tuser carries
//   the command (load or pixel). A load writes one palette entry and
//   produces no rsp_ transaction; a pixel always produces exactly one.
// rsp_ channel: the resulting pixel, tuser flags whether it was blended.
// csr_ channel: register writes, always ready; write only while idle.
// Throughput: one transaction per clock while rsp_ is not stalled. Pixels
//   pass through the seven-stage pipeline to rsp_tvalid
//   (window compare, row lookup, palette read, fill multiply, two outline
//   passes, final divide into the output register).
// Each stage holds its own valid bit; a stage advances when the one after
//   it is empty or advancing, so bubbles fill while rsp_ is stalled and
//   req_tready drops only once every stage holds a transaction.
// Reset clears the valid bits and restores register defaults; palette
//   contents stay undefined until loaded.
module palette_legend_bar_overlay_unit (
   input  logic                                clock,
   input  logic                                reset,
   // column, line, palette_index, red_in, green_in, blue_in (low bit up)
   input  logic [plbo_pkg::REQ_DATA_W-1:0]     req_tdata,
   // command
   input  logic                                req_tuser,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // red_out, green_out, blue_out (low bit up)
   output logic [plbo_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // modified
   output logic                                rsp_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [plbo_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [plbo_pkg::CSR_DATA_W-1:0]     csr_data
);
   import plbo_pkg::*;

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   logic [COORD_W-1:0] strip_left_ff, strip_top_ff, clip_left_ff, clip_top_ff;
   logic [SPAN_W-1:0]  clip_width_ff, clip_height_ff;
   logic [ALPHA_W-1:0] fill_alpha_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         strip_left_ff  <= '0;
         strip_top_ff   <= '0;
         fill_alpha_ff  <= ALPHA_W'(ALPHA_MAX);
         clip_left_ff   <= '0;
         clip_top_ff    <= '0;
         clip_width_ff  <= SPAN_W'(1 << COORD_W);
         clip_height_ff <= SPAN_W'(1 << COORD_W);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_STRIP_LEFT:  strip_left_ff  <= csr_data[COORD_W-1:0];
            CSR_STRIP_TOP:   strip_top_ff   <= csr_data[COORD_W-1:0];
            CSR_FILL_ALPHA:  fill_alpha_ff  <= csr_data[ALPHA_W-1:0];
            CSR_CLIP_LEFT:   clip_left_ff   <= csr_data[COORD_W-1:0];
            CSR_CLIP_TOP:    clip_top_ff    <= csr_data[COORD_W-1:0];
            CSR_CLIP_WIDTH:  clip_width_ff  <= csr_data;
            CSR_CLIP_HEIGHT: clip_height_ff <= csr_data;
            default: ;  // unmapped index: drop the write
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Unpack the request
   // ---------------------------------------------------------------
   logic [COORD_W-1:0] req_column, req_line;
   logic [PAL_W-1:0]   req_pal_idx;
   rgb_type            req_pixel;

   assign req_column  = req_tdata[COORD_W-1:0];
   assign req_line    = req_tdata[2*COORD_W-1:COORD_W];
   assign req_pal_idx = req_tdata[2*COORD_W+PAL_W-1:2*COORD_W];
   assign req_pixel   = req_tdata[REQ_DATA_W-1:2*COORD_W+PAL_W];

   // ---------------------------------------------------------------
   // Stage enables: a stage loads when it is empty or its content moves on
   // ---------------------------------------------------------------
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff;
   logic en1, en2, en3, en4, en5, en6, en7;

   always_comb begin
      en7 = !v7_ff || rsp_tready;
      en6 = !v6_ff || en7;
      en5 = !v5_ff || en6;
      en4 = !v4_ff || en5;
      en3 = !v3_ff || en4;
      en2 = !v2_ff || en3;
      en1 = !v1_ff || en2;
   end

   assign req_tready = en1;

   // ---------------------------------------------------------------
   // Stage 1: clip and strip window compares, strip-relative row/column
   // ---------------------------------------------------------------
   logic               cmd1_ff, hit1_ff;
   logic [ROW_W-1:0]   row1_ff;
   logic [COL_W-1:0]   col1_ff;
   logic [PAL_W-1:0]   pal_idx1_ff;
   rgb_type            pix1_ff;

   logic               hit1_in;
   logic [COORD_W-1:0] row_full, col_full;

   always_comb begin
      logic in_clip_x, in_clip_y, in_strip_x, in_strip_y;
      in_clip_x  = (req_column >= clip_left_ff) &&
                   (SUM_W'(req_column) < SUM_W'(clip_left_ff) + SUM_W'(clip_width_ff));
      in_clip_y  = (req_line >= clip_top_ff) &&
                   (SUM_W'(req_line) < SUM_W'(clip_top_ff) + SUM_W'(clip_height_ff));
      in_strip_x = (req_column >= strip_left_ff) &&
                   (SUM_W'(req_column) < SUM_W'(strip_left_ff) + SUM_W'(STRIP_WIDTH));
      in_strip_y = (req_line >= strip_top_ff) &&
                   (SUM_W'(req_line) < SUM_W'(strip_top_ff) + SUM_W'(STRIP_HEIGHT));
      hit1_in    = in_clip_x && in_clip_y && in_strip_x && in_strip_y;
      row_full   = req_line - strip_top_ff;
      col_full   = req_column - strip_left_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en1) begin
         v1_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         cmd1_ff     <= req_tuser;
         hit1_ff     <= (req_tuser == CMD_PIXEL) && hit1_in;
         // Park the row at zero off the strip so the lookup stays in range.
         row1_ff     <= hit1_in ? row_full[ROW_W-1:0] : '0;
         col1_ff     <= col_full[COL_W-1:0];
         pal_idx1_ff <= req_pal_idx;
         pix1_ff     <= req_pixel;
      end
   end

   // ---------------------------------------------------------------
   // Stage 2: row to palette index, outline edge count
   // ---------------------------------------------------------------
   logic             cmd2_ff, fill2_ff, mod2_ff;
   logic [1:0]       edges2_ff;
   logic [PAL_W-1:0] pal_idx2_ff;
   rgb_type          pix2_ff;

   logic             fill2_in;
   logic [1:0]       edges2_in;

   always_comb begin
      logic on_row_edge, on_col_edge;
      on_row_edge = (row1_ff == '0) || (row1_ff == ROW_W'(STRIP_LAST));
      on_col_edge = (col1_ff == '0) || (col1_ff == COL_W'(STRIP_WIDTH - 1));
      fill2_in    = hit1_ff && (fill_alpha_ff != '0);
      edges2_in   = hit1_ff ? ({1'b0, on_row_edge} + {1'b0, on_col_edge}) : 2'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en2) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         cmd2_ff     <= cmd1_ff;
         fill2_ff    <= fill2_in;
         edges2_ff   <= edges2_in;
         mod2_ff     <= fill2_in || (edges2_in != 2'd0);
         // Loads keep their own index; pixels take the row's gradient index.
         pal_idx2_ff <= (cmd1_ff == CMD_LOAD) ? pal_idx1_ff : GRAD_TABLE[row1_ff];
         pix2_ff     <= pix1_ff;
      end
   end

   // ---------------------------------------------------------------
   // Stage 3: palette access. Loads write here and are dropped at stage 4;
   // pixels read at the same stage, so stream order is kept.
   // ---------------------------------------------------------------
   logic    cmd3_ff, fill3_ff, mod3_ff;
   logic [1:0] edges3_ff;
   rgb_type pix3_ff;
   rgb_type pal_rd;

   plbo_palette_ram u_palette (
      .clock   (clock),
      .wr_en   (en3 && v2_ff && (cmd2_ff == CMD_LOAD)),
      .wr_addr (pal_idx2_ff),
      .wr_data (pix2_ff),
      .rd_en   (en3),
      .rd_addr (pal_idx2_ff),
      .rd_data (pal_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en3) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         cmd3_ff   <= cmd2_ff;
         fill3_ff  <= fill2_ff;
         edges3_ff <= edges2_ff;
         mod3_ff   <= mod2_ff;
         pix3_ff   <= pix2_ff;
      end
   end

   // ---------------------------------------------------------------
   // Stage 4: fill blend products. Alpha 0 and 255 fall out exactly;
   // off-strip pixels use alpha 0 with a zero source.
   // ---------------------------------------------------------------
   logic        mod4_ff;
   logic [1:0]  edges4_ff;
   rgb_sum_type sum4_ff, sum4_in;

   always_comb begin
      logic [ALPHA_W-1:0] a;
      logic [CHAN_W-1:0]  src;
      a = fill3_ff ? fill_alpha_ff : '0;
      for (int ch = 0; ch < CHAN_NUM; ch++) begin
         src = fill3_ff ? pal_rd[ch] : '0;
         sum4_in[ch] = ({{CHAN_W{1'b0}}, src} * {{CHAN_W{1'b0}}, a}) +
                       ({{CHAN_W{1'b0}}, pix3_ff[ch]} *
                        {{CHAN_W{1'b0}}, ALPHA_W'(ALPHA_MAX) - a}) +
                       PROD_W'(ROUND_BIAS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (en4) begin
         v4_ff <= v3_ff && (cmd3_ff == CMD_PIXEL);
      end
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         mod4_ff   <= mod3_ff;
         edges4_ff <= edges3_ff;
         sum4_ff   <= sum4_in;
      end
   end

   // ---------------------------------------------------------------
   // Stage 5: finish the fill, start the first outline blend
   // ---------------------------------------------------------------
   logic        mod5_ff;
   logic [1:0]  edges5_ff;
   rgb_type     cur5_ff, cur5_in;
   rgb_sum_type blk5_ff, blk5_in;

   always_comb begin
      for (int ch = 0; ch < CHAN_NUM; ch++) begin
         cur5_in[ch] = div255(sum4_ff[ch]);
         blk5_in[ch] = {{CHAN_W{1'b0}}, cur5_in[ch]} * PROD_W'(OUTLINE_KEEP) +
                       PROD_W'(ROUND_BIAS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (en5) begin
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en5) begin
         mod5_ff   <= mod4_ff;
         edges5_ff <= edges4_ff;
         cur5_ff   <= cur5_in;
         blk5_ff   <= blk5_in;
      end
   end

   // ---------------------------------------------------------------
   // Stage 6: finish the first outline blend, start the second (corners)
   // ---------------------------------------------------------------
   logic        mod6_ff;
   logic [1:0]  edges6_ff;
   rgb_type     cur6_ff, cur6_in;
   rgb_sum_type blk6_ff, blk6_in;

   always_comb begin
      logic [CHAN_W-1:0] d;
      for (int ch = 0; ch < CHAN_NUM; ch++) begin
         d = div255(blk5_ff[ch]);
         cur6_in[ch] = (edges5_ff != 2'd0) ? d : cur5_ff[ch];
         blk6_in[ch] = {{CHAN_W{1'b0}}, d} * PROD_W'(OUTLINE_KEEP) +
                       PROD_W'(ROUND_BIAS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else if (en6) begin
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en6) begin
         mod6_ff   <= mod5_ff;
         edges6_ff <= edges5_ff;
         cur6_ff   <= cur6_in;
         blk6_ff   <= blk6_in;
      end
   end

   // ---------------------------------------------------------------
   // Stage 7: output register; corners take the second outline blend
   // ---------------------------------------------------------------
   logic    mod7_ff;
   rgb_type pix7_ff, pix7_in;

   always_comb begin
      for (int ch = 0; ch < CHAN_NUM; ch++) begin
         pix7_in[ch] = (edges6_ff == 2'd2) ? div255(blk6_ff[ch]) : cur6_ff[ch];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v7_ff <= 1'b0;
      end else if (en7) begin
         v7_ff <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en7) begin
         mod7_ff <= mod6_ff;
         pix7_ff <= pix7_in;
      end
   end

   assign rsp_tvalid = v7_ff;
   assign rsp_tdata  = pix7_ff;
   assign rsp_tuser  = mod7_ff;

endmodule

// ===== test/tb_palette_legend_bar_overlay_unit.sv =====
module tb_palette_legend_bar_overlay_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import plbo_pkg::*;

   // Run shape: about 1450 random transactions spread over ten register settings.
   localparam int PHASES          = 10;
   localparam int ITEMS_PER_PHASE = 143;
   localparam int PIPE_FLUSH      = 12;      // drain margin past the block pipeline
   localparam int HOLD_CYCLES     = 80;      // long receiver hold-off
   localparam int CYCLE_LIMIT     = 400000;
   localparam int REPORT_MAX      = 10;

   typedef struct packed {
      command_type         cmd;
      logic [COORD_W-1:0]  column;
      logic [COORD_W-1:0]  line;
      logic [PAL_W-1:0]    pal_idx;
      rgb_type             color;
   } overlay_req_type;

   typedef struct packed {
      rgb_type  color;
      logic     modified;
   } overlay_rsp_type;

   typedef struct packed {
      logic [COORD_W-1:0]  strip_left;
      logic [COORD_W-1:0]  strip_top;
      logic [ALPHA_W-1:0]  fill_alpha;
      logic [COORD_W-1:0]  clip_left;
      logic [COORD_W-1:0]  clip_top;
      logic [SPAN_W-1:0]   clip_width;
      logic [SPAN_W-1:0]   clip_height;
   } overlay_cfg_type;

   // One row of the directed table. When known is set the expected pixel is
   // typed in; otherwise the predictor supplies it.
   typedef struct packed {
      command_type         cmd;
      logic [COORD_W-1:0]  column;
      logic [COORD_W-1:0]  line;
      logic [PAL_W-1:0]    pal_idx;
      logic [7:0]          red;
      logic [7:0]          green;
      logic [7:0]          blue;
      logic                known;
      logic [7:0]          exp_red;
      logic [7:0]          exp_green;
      logic [7:0]          exp_blue;
      logic                exp_mod;
   } directed_row_type;

   // ------------------------------------------------------------------
   // DUT signals, all inputs driven to known values from time zero
   // ------------------------------------------------------------------
   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   // column, line, palette_index, red_in, green_in, blue_in (low bit up)
   logic [REQ_DATA_W-1:0]  req_tdata  = '0;
   // command
   logic                   req_tuser  = 1'b0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   // red_out, green_out, blue_out (low bit up)
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   // modified
   logic                   rsp_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_data   = '0;

   palette_legend_bar_overlay_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // 20 ns period
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Predictor state: register copy, palette copy and which slots hold data
   // ------------------------------------------------------------------
   overlay_cfg_type overlay_cfg = '{12'd0, 12'd0, 8'd255, 12'd0, 12'd0, 13'd4096, 13'd4096};
   rgb_type         palette_mem [PALETTE_DEPTH];
   bit              slot_loaded [PALETTE_DEPTH];
   overlay_rsp_type expected_pixels [$];

   int            mismatches    = 0;
   int            cycle_count   = 0;
   int            burst_left    = 0;
   int            hold_requests = 0;
   int            hold_grants   = 0;
   int            hold_left     = 0;
   logic [15:0]   stall_mask    = '0;
   logic [3:0]    stall_phase   = '0;

   // Fixed register settings, extremes among them:
   //   mid-frame strip at half opacity with full clip,
   //   strip running past the last coordinate with a transparent fill,
   //   narrow clip box cutting into the strip,
   //   empty clip box,
   //   strip and clip squeezed into the last pixel,
   //   strip flush with the bottom-right corner, clip sums past the frame.
   overlay_cfg_type fixed_cfgs [6] = '{
      '{12'd100,  12'd200,  8'd128, 12'd0,    12'd0,    13'd4096, 13'd4096},
      '{12'd4090, 12'd4000, 8'd0,   12'd0,    12'd0,    13'd4096, 13'd4096},
      '{12'd500,  12'd600,  8'd255, 12'd505,  12'd650,  13'd6,    13'd20},
      '{12'd0,    12'd0,    8'd1,   12'd0,    12'd0,    13'd0,    13'd0},
      '{12'd4095, 12'd4095, 8'd254, 12'd4095, 12'd4095, 13'd1,    13'd1},
      '{12'd4080, 12'd3984, 8'd200, 12'd4000, 12'd3900, 13'd4096, 13'd4096}
   };

   // Directed rows run on the reset settings: strip at the origin, opaque
   // fill, clip box covering the whole frame.
   directed_row_type directed_rows [21] = '{
      // palette loads, index extremes first; the fifth one carries junk
      // coordinates at their maximum, which a load must ignore
      '{CMD_LOAD,  12'd0,    12'd0,    8'd255, 8'd255, 8'd255, 8'd255, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
      '{CMD_LOAD,  12'd0,    12'd0,    8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
      '{CMD_LOAD,  12'd0,    12'd0,    8'd140, 8'd18,  8'd52,  8'd86,  1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
      '{CMD_LOAD,  12'd0,    12'd0,    8'd253, 8'd10,  8'd20,  8'd30,  1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
      '{CMD_LOAD,  12'd4095, 12'd4095, 8'd2,   8'd77,  8'd88,  8'd99,  1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
      '{CMD_LOAD,  12'd0,    12'd0,    8'd117, 8'd128, 8'd64,  8'd32,  1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
      // interior strip pixels: opaque fill replaces them with the row's color
      '{CMD_PIXEL, 12'd5,    12'd50,   8'd0,   8'd1,   8'd2,   8'd3,   1'b1, 8'd18, 8'd52, 8'd86, 1'b1},
      '{CMD_PIXEL, 12'd3,    12'd1,    8'd0,   8'd200, 8'd200, 8'd200, 1'b1, 8'd10, 8'd20, 8'd30, 1'b1},
      '{CMD_PIXEL, 12'd8,    12'd110,  8'd0,   8'd0,   8'd0,   8'd0,   1'b1, 8'd77, 8'd88, 8'd99, 1'b1},
      // pixels outside the strip pass through untouched
      '{CMD_PIXEL, 12'd16,   12'd50,   8'd0,   8'd1,   8'd2,   8'd3,   1'b1, 8'd1,   8'd2,   8'd3,   1'b0},
      '{CMD_PIXEL, 12'd4095, 12'd4095, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 8'd255, 8'd255, 8'd255, 1'b0},
      '{CMD_PIXEL, 12'd5,    12'd112,  8'd0,   8'd9,   8'd9,   8'd9,   1'b1, 8'd9,   8'd9,   8'd9,   1'b0},
      '{CMD_PIXEL, 12'd4095, 12'd0,    8'd0,   8'd0,   8'd0,   8'd0,   1'b1, 8'd0,   8'd0,   8'd0,   1'b0},
      // top-left corner: white fill darkened by two outline blends
      '{CMD_PIXEL, 12'd0,    12'd0,    8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
      // bottom-right corner on the black bottom row stays black
      '{CMD_PIXEL, 12'd15,   12'd111,  8'd0,   8'd255, 8'd255, 8'd255, 1'b1, 8'd0, 8'd0, 8'd0, 1'b1},
      // single outline edges: top, left, right, bottom
      '{CMD_PIXEL, 12'd7,    12'd0,    8'd0,   8'd12,  8'd34,  8'd56,  1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
      '{CMD_PIXEL, 12'd0,    12'd50,   8'd0,   8'd12,  8'd34,  8'd56,  1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
      '{CMD_PIXEL, 12'd15,   12'd60,   8'd0,   8'd12,  8'd34,  8'd56,  1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
      '{CMD_PIXEL, 12'd9,    12'd111,  8'd0,   8'd90,  8'd90,  8'd90,  1'b1, 8'd0, 8'd0, 8'd0, 1'b1},
      // overwrite a palette slot and read it back right away
      '{CMD_LOAD,  12'd0,    12'd0,    8'd140, 8'd255, 8'd0,   8'd255, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
      '{CMD_PIXEL, 12'd5,    12'd50,   8'd0,   8'd0,   8'd0,   8'd0,   1'b1, 8'd255, 8'd0, 8'd255, 1'b1}
   };

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------
   function automatic logic [7:0] mix_channel(input int src, input int dst, input int alpha);
      if (alpha == 0) return 8'(dst);
      if (alpha >= ALPHA_MAX) return 8'(src);
      return 8'((src * alpha + dst * (ALPHA_MAX - alpha) + ROUND_BIAS) / ALPHA_MAX);
   endfunction

   // True when (x, y) lies in both the clip box and the strip. Sums are
   // taken in int so nothing wraps past the last coordinate.
   function automatic bit in_legend(input int x, input int y);
      int sl, st, cl, ct;
      sl = overlay_cfg.strip_left;
      st = overlay_cfg.strip_top;
      cl = overlay_cfg.clip_left;
      ct = overlay_cfg.clip_top;
      return x >= cl && x < cl + int'(overlay_cfg.clip_width) &&
             y >= ct && y < ct + int'(overlay_cfg.clip_height) &&
             x >= sl && x < sl + STRIP_WIDTH &&
             y >= st && y < st + STRIP_HEIGHT;
   endfunction

   // Palette slot of a strip row: top row brightest, rounded to nearest.
   function automatic logic [PAL_W-1:0] strip_color_slot(input int row);
      return PAL_W'(255 - (row * 255 + (STRIP_HEIGHT - 1) / 2) / (STRIP_HEIGHT - 1));
   endfunction

   function automatic overlay_rsp_type shade_pixel(input overlay_req_type px);
      overlay_rsp_type res;
      rgb_type         fill;
      int              row, col, edge_hits;
      res.color    = px.color;
      res.modified = 1'b0;
      if (in_legend(px.column, px.line)) begin
         row  = int'(px.line) - int'(overlay_cfg.strip_top);
         col  = int'(px.column) - int'(overlay_cfg.strip_left);
         fill = palette_mem[strip_color_slot(row)];
         for (int ch = 0; ch < CHAN_NUM; ch++) begin
            res.color[ch] = mix_channel(fill[ch], res.color[ch], overlay_cfg.fill_alpha);
         end
         res.modified = (overlay_cfg.fill_alpha != 0);
         // corners sit on a row edge and a column edge and take a black blend for each
         edge_hits = int'(row == 0) + int'(row == STRIP_HEIGHT - 1) +
                     int'(col == 0) + int'(col == STRIP_WIDTH - 1);
         repeat (edge_hits) begin
            for (int ch = 0; ch < CHAN_NUM; ch++) begin
               res.color[ch] = mix_channel(0, res.color[ch], OUTLINE_ALPHA);
            end
            res.modified = 1'b1;
         end
      end
      return res;
   endfunction

   // ------------------------------------------------------------------
   // Random stimulus helpers
   // ------------------------------------------------------------------
   // Offset just outside or just inside either end of a span: -1, 0, span-1, span.
   function automatic int edge_offset(input int span);
      int k;
      k = $urandom_range(0, 3);
      return (k < 2) ? k - 1 : span + k - 3;
   endfunction

   function automatic logic [COORD_W-1:0] clamp_coord(input int v);
      if (v < 0) return '0;
      if (v > 4095) return '1;
      return COORD_W'(v);
   endfunction

   // Mostly pixels aimed at the strip and its border, some at the clip
   // border, the rest spread over the frame; about one in seven is a load.
   function automatic overlay_req_type random_item();
      overlay_req_type it;
      int              pick, dx, dy;
      it.color   = 24'($urandom);
      it.pal_idx = 8'($urandom);
      it.column  = 12'($urandom);
      it.line    = 12'($urandom);
      it.cmd     = ($urandom_range(0, 99) < 15) ? CMD_LOAD : CMD_PIXEL;
      if (it.cmd == CMD_PIXEL) begin
         pick = $urandom_range(0, 9);
         dx   = $urandom_range(0, STRIP_WIDTH - 1);
         dy   = $urandom_range(0, STRIP_HEIGHT - 1);
         if (pick == 6) dx = edge_offset(STRIP_WIDTH);
         if (pick == 7) dy = edge_offset(STRIP_HEIGHT);
         if (pick <= 7) begin
            it.column = COORD_W'(int'(overlay_cfg.strip_left) + dx);
            it.line   = COORD_W'(int'(overlay_cfg.strip_top) + dy);
         end else if (pick == 8) begin
            it.column = COORD_W'(int'(overlay_cfg.clip_left) + edge_offset(overlay_cfg.clip_width));
            it.line   = COORD_W'(int'(overlay_cfg.clip_top) + edge_offset(overlay_cfg.clip_height));
         end
      end
      return it;
   endfunction

   function automatic overlay_cfg_type random_config();
      overlay_cfg_type c;
      int              k;
      c.strip_left = 12'($urandom);
      c.strip_top  = 12'($urandom);
      k = $urandom_range(0, 3);
      c.fill_alpha = (k == 0) ? 8'd0 : (k == 1) ? 8'd255 : 8'($urandom);
      case ($urandom_range(0, 2))
         0: begin
            c.clip_left   = '0;
            c.clip_top    = '0;
            c.clip_width  = 13'd4096;
            c.clip_height = 13'd4096;
         end
         1: begin
            // clip box cutting across the strip
            c.clip_left   = clamp_coord(int'(c.strip_left) + int'($urandom_range(0, 20)) - 10);
            c.clip_top    = clamp_coord(int'(c.strip_top) + int'($urandom_range(0, 120)) - 10);
            c.clip_width  = SPAN_W'($urandom_range(0, 40));
            c.clip_height = SPAN_W'($urandom_range(0, 140));
         end
         default: begin
            c.clip_left   = 12'($urandom);
            c.clip_top    = 12'($urandom);
            c.clip_width  = SPAN_W'($urandom_range(0, 4096));
            c.clip_height = SPAN_W'($urandom_range(0, 4096));
         end
      endcase
      return c;
   endfunction

   // ------------------------------------------------------------------
   // Driver tasks: each is entered right after a falling edge and returns
   // right after a falling edge.
   // ------------------------------------------------------------------
   // Offer one transaction and hold it until accepted. Record the expected
   // pixel (or the palette write) only after the edge has passed, so the
   // result checker never sees a prediction from the same edge.
   task automatic offer_item(input overlay_req_type it, input bit typed,
                             input overlay_rsp_type typed_rsp);
      req_tvalid <= 1'b1;
      req_tuser  <= it.cmd;
      req_tdata  <= {it.color, it.pal_idx, it.line, it.column};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      if (it.cmd == CMD_LOAD) begin
         palette_mem[it.pal_idx] = it.color;
         slot_loaded[it.pal_idx] = 1'b1;
      end else begin
         expected_pixels.push_back(typed ? typed_rsp : shade_pixel(it));
      end
   endtask

   // Burst pacing: random burst length, then a random gap (none a quarter of the time).
   task automatic pace_sender();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   endtask

   // Stop offering, wait for every expected pixel, then let trailing loads
   // clear the pipeline.
   task automatic drain_pipeline();
      req_tvalid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (PIPE_FLUSH) @(posedge clock);
      @(negedge clock);
   endtask

   // Write one register; valid stays high so back-to-back writes flow.
   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic apply_config(input overlay_cfg_type c);
      write_reg(CSR_STRIP_LEFT,  CSR_DATA_W'(c.strip_left));
      write_reg(CSR_STRIP_TOP,   CSR_DATA_W'(c.strip_top));
      write_reg(CSR_FILL_ALPHA,  CSR_DATA_W'(c.fill_alpha));
      write_reg(CSR_CLIP_LEFT,   CSR_DATA_W'(c.clip_left));
      write_reg(CSR_CLIP_TOP,    CSR_DATA_W'(c.clip_top));
      write_reg(CSR_CLIP_WIDTH,  c.clip_width);
      write_reg(CSR_CLIP_HEIGHT, c.clip_height);
      csr_valid   <= 1'b0;
      overlay_cfg  = c;
   endtask

   task automatic note_mismatch(input string what);
      mismatches++;
      if (mismatches <= REPORT_MAX) $display("[%0t] mismatch: %s", $realtime, what);
   endtask

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   initial begin : stimulus
      overlay_req_type it;
      overlay_req_type fill_load;
      overlay_rsp_type typed;
      overlay_cfg_type c;

      // hold reset, then release it
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // Directed table on the reset settings.
      foreach (directed_rows[i]) begin
         it.cmd         = directed_rows[i].cmd;
         it.column      = directed_rows[i].column;
         it.line        = directed_rows[i].line;
         it.pal_idx     = directed_rows[i].pal_idx;
         it.color       = {directed_rows[i].blue, directed_rows[i].green, directed_rows[i].red};
         typed.color    = {directed_rows[i].exp_blue, directed_rows[i].exp_green,
                           directed_rows[i].exp_red};
         typed.modified = directed_rows[i].exp_mod;
         offer_item(it, directed_rows[i].known, typed);
         pace_sender();
      end

      // Random phases. Each phase starts with the sender paused until every
      // expected pixel has come back, then rewrites all registers.
      for (int ph = 0; ph < PHASES; ph++) begin
         drain_pipeline();
         c = (ph < 6) ? fixed_cfgs[ph] : random_config();
         apply_config(c);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // ask the receiver for a long hold-off while we keep offering
            if (n == 50 && ph % 3 == 0) hold_requests++;
            it = random_item();
            // never read a palette slot that was never loaded: load it first
            if (it.cmd == CMD_PIXEL && in_legend(it.column, it.line) &&
                !slot_loaded[strip_color_slot(int'(it.line) - int'(overlay_cfg.strip_top))]) begin
               fill_load.cmd     = CMD_LOAD;
               fill_load.column  = 12'($urandom);
               fill_load.line    = 12'($urandom);
               fill_load.pal_idx = strip_color_slot(int'(it.line) - int'(overlay_cfg.strip_top));
               fill_load.color   = 24'($urandom);
               offer_item(fill_load, 1'b0, '0);
               pace_sender();
            end
            offer_item(it, 1'b0, '0);
            pace_sender();
         end
      end

      drain_pipeline();
      if (mismatches == 0 && expected_pixels.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // ------------------------------------------------------------------
   // Receiver: stall on a random 16-bit mask refreshed each round (clear about a
   // quarter of the time), or hold off entirely when the sender asks.
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (hold_grants != hold_requests) begin
         hold_grants = hold_requests;
         hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         if (stall_phase == 0) begin
            stall_mask = ($urandom_range(0, 3) == 0) ? 16'h0000 : 16'($urandom & $urandom);
         end
         rsp_tready  <= !stall_mask[stall_phase];
         stall_phase  = stall_phase + 4'd1;
      end
   end

   // ------------------------------------------------------------------
   // Result checker: compare each accepted pixel with the oldest expectation.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : check_rsp
      overlay_rsp_type want;
      rgb_type         got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (expected_pixels.size() == 0) begin
            note_mismatch($sformatf("unexpected pixel r=%0d g=%0d b=%0d mod=%0d",
                                    got[0], got[1], got[2], rsp_tuser));
         end else begin
            want = expected_pixels.pop_front();
            if (got[0] != want.color[0] || got[1] != want.color[1] ||
                got[2] != want.color[2] || rsp_tuser != want.modified) begin
               note_mismatch($sformatf(
                  "expected r=%0d g=%0d b=%0d mod=%0d, got r=%0d g=%0d b=%0d mod=%0d",
                  want.color[0], want.color[1], want.color[2], want.modified,
                  got[0], got[1], got[2], rsp_tuser));
            end
         end
      end
   end

   // Watchdog on a cycle count.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

endmodule
